### hw/rtl/iar_pkg.sv
// Types, constants and the divider step shared by the audio packet receiver.
`default_nettype none

package iar_pkg;

  // Field widths of the packet header, the result word and the registers.
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned RING_W     = 21;
  localparam int unsigned OFFSET_W   = 20;
  localparam int unsigned COPY_W     = 10;
  localparam int unsigned REASON_W   = 3;
  localparam int unsigned CFG_IDX_W  = 8;

  // Packet format constants.
  localparam int unsigned MIN_PACKET_LEN  = 20;
  localparam int unsigned PAYLOAD_HDR_LEN = 16;
  localparam int unsigned CAPTURE_HDR_LEN = 4;
  localparam int unsigned RING_LIMIT      = 1048576;

  // Register reset values.
  localparam logic [RING_W-1:0] RING_BYTES_RST  = 21'd65536;
  localparam logic [RING_W-1:0] BLOCK_BYTES_RST = 21'd4096;

  // One divider step per bit of the 32-bit dividend.
  localparam int unsigned DIV_STEPS  = WORD_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  typedef enum logic [REASON_W-1:0] {
    RSN_NONE          = 3'd0,
    RSN_SHORT_PACKET  = 3'd1,
    RSN_BAD_SIGNATURE = 3'd2,
    RSN_BAD_COUNT     = 3'd3,
    RSN_SHORT_PAYLOAD = 3'd4
  } reason_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STREAM_ENABLE      = 8'd0,
    CFG_EXPECTED_SIGNATURE = 8'd1,
    CFG_RING_BYTES         = 8'd2,
    CFG_BLOCK_BYTES        = 8'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  // One restoring division step: shift in the next dividend bit and subtract
  // the divisor when it fits. Returns the quotient bit above the remainder.
  function automatic logic [RING_W:0] div_step(input logic [RING_W-1:0] rem,
                                               input logic              dbit,
                                               input logic [RING_W-1:0] divisor);
    logic [RING_W:0] shifted;
    logic [RING_W:0] diff;
    logic [RING_W:0] res;
    shifted = {rem, dbit};
    diff    = shifted - {1'b0, divisor};
    if (shifted >= {1'b0, divisor}) begin
      res = {1'b1, diff[RING_W-1:0]};
    end else begin
      res = {1'b0, shifted[RING_W-1:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/iso_audio_packet_receiver.sv
// Top level of the isochronous audio packet receiver.
`default_nettype none

// The receiver checks the parsed header of one audio packet per word and
// returns one result word for it. Checks run in a fixed order (short packet,
// bad signature, bad sample count, short payload) and the first failure is
// reported. An accepted packet updates the expected running sample total and
// the wrapping gap counter; when streaming is enabled and the ring size is
// nonzero it also advances the 32-bit byte write pointer and reports the ring
// offset and copy size for the DMA engine, plus a block interrupt flag. A
// rejected packet, or one not written to the ring, goes straight to the done
// state and from there into the output register. A packet that is written to
// the ring first passes a bit-serial restoring divider that shifts the old and
// new write pointers through one bit per cycle, reducing the old pointer modulo
// the ring size and both pointers by the block size at once.
// The quotients are never stored; their bits are compared as they appear.
// The receiver takes the next word as soon as a result has moved into the
// output register, even while that result waits for the sink. Configuration
// registers are meant to be written only while no packet is in flight; the
// configuration channel is always ready.
module iso_audio_packet_receiver #(
  parameter int unsigned MAX_SAMPLES = 128
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,

  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [iar_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire  [iar_pkg::WORD_W-1:0]            cfg_data_i,

  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [iar_pkg::LEN_W-1:0]             packet_length_i,
  input  wire  [iar_pkg::LEN_W-1:0]             captured_length_i,
  input  wire  [iar_pkg::WORD_W-1:0]            signature_i,
  input  wire  [iar_pkg::WORD_W-1:0]            sample_count_i,
  input  wire  [iar_pkg::WORD_W-1:0]            sample_total_i,

  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic                                  accepted_o,
  output logic [iar_pkg::REASON_W-1:0]          reject_reason_o,
  output logic [iar_pkg::OFFSET_W-1:0]          ring_offset_o,
  output logic [iar_pkg::COPY_W-1:0]            copy_bytes_o,
  output logic                                  gap_detected_o,
  output logic [iar_pkg::WORD_W-1:0]            dropped_count_o,
  output logic                                  block_interrupt_o
);

  import iar_pkg::*;

  // Width of a sample count that has passed the range check.
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned NEED_W = LEN_W + 1;

  // Configuration registers.
  logic                stream_enable_q;
  logic [WORD_W-1:0]   expected_signature_q;
  logic [RING_W-1:0]   ring_bytes_q;
  logic [RING_W-1:0]   block_bytes_q;

  // Architectural state.
  logic [WORD_W-1:0]   expected_total_q;
  logic [WORD_W-1:0]   gap_counter_q;
  logic [WORD_W-1:0]   write_pointer_q;

  // Control.
  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q;
  logic                in_accept;
  logic                out_load;

  // Pending result of the packet in flight.
  logic                res_accepted_q;
  reason_e             res_reason_q;
  logic [COPY_W-1:0]   res_copy_q;
  logic                res_gap_q;
  logic [WORD_W-1:0]   res_dropped_q;
  logic                res_write_q;

  // Bit-serial divider.
  logic [WORD_W-1:0]   old_sh_q;
  logic [WORD_W-1:0]   new_sh_q;
  logic [RING_W-1:0]   rem_ring_q;
  logic [RING_W-1:0]   rem_old_q;
  logic [RING_W-1:0]   rem_new_q;
  logic                differ_q;
  logic [RING_W:0]     step_ring;
  logic [RING_W:0]     step_old;
  logic [RING_W:0]     step_new;

  // Header checks, evaluated in the acceptance cycle.
  logic                short_packet;
  logic                bad_count;
  logic [NEED_W-1:0]   payload_need;
  reason_e             reason;
  logic                pkt_ok;
  logic                gap;
  logic                do_write;
  logic [WORD_W-1:0]   copy_bytes32;
  logic [RING_W-1:0]   ring_eff;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_o || !out_stall_i);

  // Ring sizes above the limit are clamped to it.
  assign ring_eff = (ring_bytes_q > RING_W'(RING_LIMIT)) ? RING_W'(RING_LIMIT) : ring_bytes_q;

  always_comb begin
    short_packet = (packet_length_i < LEN_W'(MIN_PACKET_LEN)) ||
                   ({1'b0, captured_length_i} <
                    ({1'b0, packet_length_i} + NEED_W'(CAPTURE_HDR_LEN)));
    bad_count    = (sample_count_i == '0) || (sample_count_i > WORD_W'(MAX_SAMPLES));
    // Only consulted once the count is known to be in range, so the low bits suffice.
    payload_need = NEED_W'(PAYLOAD_HDR_LEN) + NEED_W'({sample_count_i[CNT_W-1:0], 2'b00});
    if (short_packet) begin
      reason = RSN_SHORT_PACKET;
    end else if (signature_i != expected_signature_q) begin
      reason = RSN_BAD_SIGNATURE;
    end else if (bad_count) begin
      reason = RSN_BAD_COUNT;
    end else if ({1'b0, packet_length_i} < payload_need) begin
      reason = RSN_SHORT_PAYLOAD;
    end else begin
      reason = RSN_NONE;
    end
    pkt_ok       = (reason == RSN_NONE);
    gap          = pkt_ok && (expected_total_q != '0) && (sample_total_i != expected_total_q);
    do_write     = pkt_ok && stream_enable_q && (ring_bytes_q != '0);
    copy_bytes32 = {sample_count_i[WORD_W-3:0], 2'b00};
  end

  // One restoring step for each of the three divisions.
  always_comb begin
    step_ring = div_step(rem_ring_q, old_sh_q[WORD_W-1], ring_eff);
    step_old  = div_step(rem_old_q, old_sh_q[WORD_W-1], block_bytes_q);
    step_new  = div_step(rem_new_q, new_sh_q[WORD_W-1], block_bytes_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = do_write ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_enable_q      <= 1'b0;
      expected_signature_q <= '0;
      ring_bytes_q         <= RING_BYTES_RST;
      block_bytes_q        <= BLOCK_BYTES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_STREAM_ENABLE:      stream_enable_q      <= cfg_data_i[0];
        CFG_EXPECTED_SIGNATURE: expected_signature_q <= cfg_data_i;
        CFG_RING_BYTES:         ring_bytes_q         <= cfg_data_i[RING_W-1:0];
        CFG_BLOCK_BYTES:        block_bytes_q        <= cfg_data_i[RING_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stream state follows each accepted packet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_total_q <= '0;
      gap_counter_q    <= '0;
      write_pointer_q  <= '0;
      step_q           <= '0;
    end else begin
      if (in_accept && pkt_ok) begin
        expected_total_q <= sample_total_i + sample_count_i;
        if (gap) begin
          gap_counter_q <= gap_counter_q + 1'b1;
        end
        if (do_write) begin
          write_pointer_q <= write_pointer_q + copy_bytes32;
        end
      end
      if (state_q == ST_DIV) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  // Pending result and divider datapath.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_accepted_q <= pkt_ok;
      res_reason_q   <= reason;
      res_copy_q     <= do_write ? copy_bytes32[COPY_W-1:0] : '0;
      res_gap_q      <= gap;
      res_dropped_q  <= gap ? gap_counter_q + 1'b1 : gap_counter_q;
      res_write_q    <= do_write;
      old_sh_q       <= write_pointer_q;
      new_sh_q       <= write_pointer_q + copy_bytes32;
      rem_ring_q     <= '0;
      rem_old_q      <= '0;
      rem_new_q      <= '0;
      differ_q       <= 1'b0;
    end else if (state_q == ST_DIV) begin
      old_sh_q   <= {old_sh_q[WORD_W-2:0], 1'b0};
      new_sh_q   <= {new_sh_q[WORD_W-2:0], 1'b0};
      rem_ring_q <= step_ring[RING_W-1:0];
      rem_old_q  <= step_old[RING_W-1:0];
      rem_new_q  <= step_new[RING_W-1:0];
      differ_q   <= differ_q || (step_old[RING_W] != step_new[RING_W]);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      accepted_o        <= res_accepted_q;
      reject_reason_o   <= res_reason_q;
      ring_offset_o     <= res_write_q ? rem_ring_q[OFFSET_W-1:0] : '0;
      copy_bytes_o      <= res_copy_q;
      gap_detected_o    <= res_gap_q;
      dropped_count_o   <= res_dropped_q;
      // A zero block size raises the interrupt on every written packet.
      block_interrupt_o <= res_write_q && ((block_bytes_q == '0) || differ_q);
    end
  end

  // A new result shows up only after the result stage handed it over.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result appeared without a finished packet");

  // The divider always finishes after its fixed number of steps.
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && step_q == STEP_W'(DIV_STEPS - 1)) |=> (state_q == ST_DONE))
    else $error("divider overran its step count");

  // A rejected packet carries no copy, offset, interrupt or gap flag.
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |->
      (copy_bytes_o == '0 && ring_offset_o == '0 && !block_interrupt_o && !gap_detected_o))
    else $error("rejected packet reports copy side effects");

  // The accepted flag agrees with the reject reason.
  a_reason_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (reject_reason_o == RSN_NONE)))
    else $error("accepted flag and reject reason disagree");

endmodule

`default_nettype wire

### tb/iar_result_checker.sv
// Result checker for the audio packet receiver: predicts every result word and compares it.
`timescale 1ns / 1ps

module iar_result_checker #(
  parameter int unsigned MAX_SAMPLES = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [iar_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [iar_pkg::WORD_W-1:0]    cfg_data_i,

  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [iar_pkg::LEN_W-1:0]     packet_length_i,
  input  logic [iar_pkg::LEN_W-1:0]     captured_length_i,
  input  logic [iar_pkg::WORD_W-1:0]    signature_i,
  input  logic [iar_pkg::WORD_W-1:0]    sample_count_i,
  input  logic [iar_pkg::WORD_W-1:0]    sample_total_i,

  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          accepted_i,
  input  logic [iar_pkg::REASON_W-1:0]  reject_reason_i,
  input  logic [iar_pkg::OFFSET_W-1:0]  ring_offset_i,
  input  logic [iar_pkg::COPY_W-1:0]    copy_bytes_i,
  input  logic                          gap_detected_i,
  input  logic [iar_pkg::WORD_W-1:0]    dropped_count_i,
  input  logic                          block_interrupt_i,

  output int                            pending_o,
  output int                            mismatch_count_o,
  output int                            results_checked_o
);

  import iar_pkg::*;

  localparam int unsigned BYTES_PER_SAMPLE = 4;

  typedef struct packed {
    logic                accepted;
    reason_e             reason;
    logic [OFFSET_W-1:0] offset;
    logic [COPY_W-1:0]   copy_bytes;
    logic                gap;
    logic [WORD_W-1:0]   dropped;
    logic                blk_int;
  } packet_result_t;

  // Register copies.
  logic              stream_on;
  logic [WORD_W-1:0] want_signature;
  logic [RING_W-1:0] ring_len;
  logic [RING_W-1:0] block_size;

  // Receiver state copies.
  logic [WORD_W-1:0] next_total;
  logic [WORD_W-1:0] gap_tally;
  logic [WORD_W-1:0] byte_pointer;

  packet_result_t awaited_results[$];

  initial begin
    mismatch_count_o  = 0;
    results_checked_o = 0;
  end

  // Judges one packet header and advances the receiver state copies.
  function automatic packet_result_t judge_packet(input logic [LEN_W-1:0]  plen,
                                                  input logic [LEN_W-1:0]  caplen,
                                                  input logic [WORD_W-1:0] sig,
                                                  input logic [WORD_W-1:0] cnt,
                                                  input logic [WORD_W-1:0] total);
    packet_result_t r;
    logic [WORD_W-1:0] plen_w;
    logic [WORD_W-1:0] ring_eff;
    logic [WORD_W-1:0] old_ptr;
    logic [WORD_W-1:0] nbytes;
    logic [WORD_W-1:0] offs;
    r      = '0;
    plen_w = {16'b0, plen};
    if (plen_w < MIN_PACKET_LEN || {16'b0, caplen} < plen_w + CAPTURE_HDR_LEN) begin
      r.reason = RSN_SHORT_PACKET;
    end else if (sig != want_signature) begin
      r.reason = RSN_BAD_SIGNATURE;
    end else if (cnt == 0 || cnt > MAX_SAMPLES) begin
      r.reason = RSN_BAD_COUNT;
    end else if (plen_w < PAYLOAD_HDR_LEN + cnt * BYTES_PER_SAMPLE) begin
      r.reason = RSN_SHORT_PAYLOAD;
    end else begin
      r.reason = RSN_NONE;
    end
    r.accepted = (r.reason == RSN_NONE);
    if (r.accepted) begin
      ring_eff = {11'b0, ring_len};
      if (ring_eff > RING_LIMIT) begin
        ring_eff = RING_LIMIT;
      end
      // A zero expected total means the stream has just started or wrapped.
      if (next_total != 0 && total != next_total) begin
        r.gap     = 1'b1;
        gap_tally = gap_tally + 1;
      end
      next_total = total + cnt;
      if (stream_on && ring_eff != 0) begin
        old_ptr      = byte_pointer;
        nbytes       = cnt * BYTES_PER_SAMPLE;
        offs         = old_ptr % ring_eff;
        byte_pointer = old_ptr + nbytes;
        r.offset     = offs[OFFSET_W-1:0];
        r.copy_bytes = nbytes[COPY_W-1:0];
        if (block_size == 0) begin
          r.blk_int = 1'b1;
        end else begin
          r.blk_int = (old_ptr / {11'b0, block_size}) != (byte_pointer / {11'b0, block_size});
        end
      end
    end
    r.dropped = gap_tally;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    packet_result_t want;
    if (!rst_ni) begin
      stream_on      = 1'b0;
      want_signature = '0;
      ring_len       = RING_BYTES_RST;
      block_size     = BLOCK_BYTES_RST;
      next_total     = '0;
      gap_tally      = '0;
      byte_pointer   = '0;
      awaited_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_STREAM_ENABLE:      stream_on      = cfg_data_i[0];
          CFG_EXPECTED_SIGNATURE: want_signature = cfg_data_i;
          CFG_RING_BYTES:         ring_len       = cfg_data_i[RING_W-1:0];
          CFG_BLOCK_BYTES:        block_size     = cfg_data_i[RING_W-1:0];
          default: ;
        endcase
      end
      // The oldest word leaves before a new packet joins the queue.
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result word arrived with no packet waiting for it");
          mismatch_count_o++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("accepted", want.accepted, accepted_i);
          compare_field("reject_reason", want.reason, reject_reason_i);
          compare_field("ring_offset", want.offset, ring_offset_i);
          compare_field("copy_bytes", want.copy_bytes, copy_bytes_i);
          compare_field("gap_detected", want.gap, gap_detected_i);
          compare_field("dropped_count", want.dropped, dropped_count_i);
          compare_field("block_interrupt", want.blk_int, block_interrupt_i);
          results_checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(judge_packet(packet_length_i, captured_length_i,
                                               signature_i, sample_count_i,
                                               sample_total_i));
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

### tb/tb.sv
// Top of the audio packet receiver testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import iar_pkg::*;

  localparam int unsigned MAX_SAMPLES    = 128;
  localparam int          PHASES         = 12;
  localparam int          PHASE_PACKETS  = 111;
  // No handshake on any channel for this many cycles means the block hung.
  // The slowest word waits only for the divider and short random stalls, so
  // this is far beyond any correct run.
  localparam int          WATCHDOG_LIMIT = 4000;

  logic                 clk_i;
  logic                 rst_ni            = 1'b0;

  logic                 cfg_valid_i       = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i       = '0;
  logic [WORD_W-1:0]    cfg_data_i        = '0;

  logic                 in_valid_i        = 1'b0;
  logic                 in_stall_o;
  logic [LEN_W-1:0]     packet_length_i   = '0;
  logic [LEN_W-1:0]     captured_length_i = '0;
  logic [WORD_W-1:0]    signature_i       = '0;
  logic [WORD_W-1:0]    sample_count_i    = '0;
  logic [WORD_W-1:0]    sample_total_i    = '0;

  logic                 out_valid_o;
  logic                 out_stall_i       = 1'b0;
  logic                 accepted_o;
  logic [REASON_W-1:0]  reject_reason_o;
  logic [OFFSET_W-1:0]  ring_offset_o;
  logic [COPY_W-1:0]    copy_bytes_o;
  logic                 gap_detected_o;
  logic [WORD_W-1:0]    dropped_count_o;
  logic                 block_interrupt_o;

  int                   pending;
  int                   mismatches;
  int                   results_checked;

  // When set, neither the sender nor the sink ever idles.
  logic                 no_idle           = 1'b0;

  // Stimulus bookkeeping: the signature the block currently wants and the
  // running total that keeps a well-formed stream free of gaps.
  logic [WORD_W-1:0]    cur_signature     = '0;
  logic [WORD_W-1:0]    stream_total      = '0;
  int                   packets_sent      = 0;
  int                   well_formed_sent  = 0;
  int                   settings_applied  = 0;
  int                   idle_cycles       = 0;

  iso_audio_packet_receiver #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .packet_length_i,
    .captured_length_i,
    .signature_i,
    .sample_count_i,
    .sample_total_i,
    .out_valid_o,
    .out_stall_i,
    .accepted_o,
    .reject_reason_o,
    .ring_offset_o,
    .copy_bytes_o,
    .gap_detected_o,
    .dropped_count_o,
    .block_interrupt_o
  );

  iar_result_checker #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_i        (in_stall_o),
    .packet_length_i,
    .captured_length_i,
    .signature_i,
    .sample_count_i,
    .sample_total_i,
    .out_valid_i       (out_valid_o),
    .out_stall_i,
    .accepted_i        (accepted_o),
    .reject_reason_i   (reject_reason_o),
    .ring_offset_i     (ring_offset_o),
    .copy_bytes_i      (copy_bytes_o),
    .gap_detected_i    (gap_detected_o),
    .dropped_count_i   (dropped_count_o),
    .block_interrupt_i (block_interrupt_o),
    .pending_o         (pending),
    .mismatch_count_o  (mismatches),
    .results_checked_o (results_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The sink stalls about a third of the cycles, except in the stretch where
  // idling is switched off.
  always @(posedge clk_i) begin
    out_stall_i <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 33);
  end

  // The watchdog restarts on any handshake of any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** iso_audio_packet_receiver: FAILED **");
      $finish;
    end
  end

  // Offers one packet header and returns at the edge that takes it. Valid is
  // left high on return, so the next call can present its word in the same
  // step without lowering valid first.
  task automatic push_packet(input logic [LEN_W-1:0]  plen,
                             input logic [LEN_W-1:0]  caplen,
                             input logic [WORD_W-1:0] sig,
                             input logic [WORD_W-1:0] cnt,
                             input logic [WORD_W-1:0] total);
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    packet_length_i   <= plen;
    captured_length_i <= caplen;
    signature_i       <= sig;
    sample_count_i    <= cnt;
    sample_total_i    <= total;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    packets_sent++;
  endtask

  // Stops sending and waits until every expected word has come back. The
  // first edge lets the checker count a packet taken at the current edge.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Writes one register. Valid stays high so writes can follow back to back;
  // the caller lowers it after the last one.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
  endtask

  // Brings the block to rest and writes all four registers, plus one write to
  // an unused index that must change nothing. When junk_high is set, the bits
  // above each register's width carry random values that must be ignored.
  task automatic apply_setting(input logic              en,
                               input logic [WORD_W-1:0] sig,
                               input logic [RING_W-1:0] ring,
                               input logic [RING_W-1:0] blk,
                               input logic              junk_high);
    logic [WORD_W-1:0] high;
    drain();
    // Leave a few quiet cycles between the last result and the register writes.
    repeat (4) @(posedge clk_i);
    high = junk_high ? $urandom : '0;
    cfg_write(CFG_STREAM_ENABLE, {high[WORD_W-1:1], en});
    cfg_write(CFG_EXPECTED_SIGNATURE, sig);
    cfg_write(CFG_RING_BYTES, {high[WORD_W-1:RING_W], ring});
    cfg_write(CFG_BLOCK_BYTES, {high[WORD_W-1:RING_W], blk});
    cfg_write(CFG_IDX_W'($urandom_range(4, 255)), $urandom);
    cfg_valid_i <= 1'b0;
    cur_signature = sig;
    settings_applied++;
  endtask

  // Builds one random packet. Three quarters are well formed and carry on the
  // running total, with an occasional jump to cause a gap or a total that
  // makes the expected total wrap to zero. The rest are pure noise or break
  // exactly one check: length, signature, sample count or payload size.
  task automatic random_packet();
    int unsigned       kind;
    int unsigned       min_len;
    int unsigned       cap_hi;
    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  caplen;
    logic [WORD_W-1:0] sig;
    logic [WORD_W-1:0] cnt;
    logic [WORD_W-1:0] total;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       cnt = 1;
      1:       cnt = MAX_SAMPLES;
      default: cnt = $urandom_range(1, MAX_SAMPLES);
    endcase
    min_len = PAYLOAD_HDR_LEN + 4 * cnt;
    if (min_len < MIN_PACKET_LEN) begin
      min_len = MIN_PACKET_LEN;
    end
    if ($urandom_range(0, 9) == 0) begin
      plen = LEN_W'($urandom_range(min_len, 65531));
    end else begin
      plen = LEN_W'(min_len + $urandom_range(0, 32));
    end
    if ($urandom_range(0, 3) == 0) begin
      caplen = plen + LEN_W'(CAPTURE_HDR_LEN);
    end else begin
      caplen = LEN_W'($urandom_range(plen + CAPTURE_HDR_LEN, 65535));
    end
    sig   = cur_signature;
    total = stream_total;
    if ($urandom_range(0, 9) == 0) begin
      total = $urandom;
    end else if ($urandom_range(0, 49) == 0) begin
      total = 32'd0 - cnt;
    end

    if (kind < 75) begin
      stream_total = total + cnt;
      well_formed_sent++;
    end else if (kind < 80) begin
      plen   = LEN_W'($urandom);
      caplen = LEN_W'($urandom);
      sig    = $urandom;
      cnt    = $urandom;
      total  = $urandom;
    end else if (kind < 85) begin
      if ($urandom_range(0, 1) == 0) begin
        plen = LEN_W'($urandom_range(0, MIN_PACKET_LEN - 1));
      end else begin
        // Long enough, but fewer bytes captured than the header promises.
        plen   = LEN_W'($urandom_range(MIN_PACKET_LEN, 65535));
        cap_hi = plen + CAPTURE_HDR_LEN - 1;
        if (cap_hi > 65535) begin
          cap_hi = 65535;
        end
        caplen = LEN_W'($urandom_range(0, cap_hi));
      end
    end else if (kind < 90) begin
      sig = cur_signature ^ (($urandom_range(0, 1) == 0) ? (32'h1 << $urandom_range(0, 31))
                                                         : ($urandom | 32'h1));
    end else if (kind < 95) begin
      cnt = ($urandom_range(0, 1) == 0) ? 32'd0
                                         : $urandom_range(MAX_SAMPLES + 1, 32'hFFFF_FFFF);
    end else begin
      // The payload falls short of the claimed samples by at least one byte.
      if (cnt < 2) begin
        cnt = 32'd2;
      end
      plen   = LEN_W'($urandom_range(MIN_PACKET_LEN, PAYLOAD_HDR_LEN + 4 * cnt - 1));
      caplen = LEN_W'(plen + CAPTURE_HDR_LEN + $urandom_range(0, 100));
    end
    push_packet(plen, caplen, sig, cnt, total);
  endtask

  initial begin
    logic              en;
    logic [WORD_W-1:0] sig;
    logic [RING_W-1:0] ring;
    logic [RING_W-1:0] blk;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings: streaming off, signature zero.
    // Short packets: below the minimum length, capture one byte short, the
    // largest length that cannot fit, and an all-zero header.
    push_packet(16'd19, 16'hFFFF, 32'h0, 32'd1, 32'd0);
    push_packet(16'd20, 16'd23, 32'h0, 32'd1, 32'd0);
    push_packet(16'hFFFF, 16'hFFFF, 32'h0, 32'd1, 32'd0);
    push_packet(16'd0, 16'd0, 32'h0, 32'd0, 32'd0);
    // Wrong signature, then sample counts of zero, one over the maximum and
    // the largest value, then a payload too short for two samples.
    push_packet(16'd20, 16'd24, 32'h1, 32'd1, 32'd0);
    push_packet(16'd20, 16'd24, 32'h0, 32'd0, 32'd0);
    push_packet(16'd20, 16'd24, 32'h0, MAX_SAMPLES + 1, 32'd0);
    push_packet(16'd20, 16'd24, 32'h0, 32'hFFFF_FFFF, 32'd0);
    push_packet(16'd20, 16'd24, 32'h0, 32'd2, 32'd0);
    // The expected total wraps to zero here, so the next packet starts a
    // fresh stream and is not checked for a gap even with an odd total.
    push_packet(16'd20, 16'd24, 32'h0, 32'd1, 32'hFFFF_FFFF);
    push_packet(16'd528, 16'hFFFF, 32'h0, MAX_SAMPLES, 32'h1234_5678);
    // A jump in the total is a gap; the packet after it continues cleanly.
    push_packet(16'd528, 16'd532, 32'h0, MAX_SAMPLES, 32'd0);
    push_packet(16'd65531, 16'hFFFF, 32'h0, 32'd1, MAX_SAMPLES);

    // Streaming on with the smallest ring and an interrupt on every written packet.
    apply_setting(1'b1, 32'hFFFF_FFFF, 21'd4, 21'd0, 1'b0);
    push_packet(16'd20, 16'd24, 32'hFFFF_FFFF, 32'd1, MAX_SAMPLES + 1);
    push_packet(16'd528, 16'd532, 32'hFFFF_FFFF, MAX_SAMPLES, MAX_SAMPLES + 2);
    push_packet(16'd528, 16'd532, 32'h0, MAX_SAMPLES, MAX_SAMPLES * 2 + 2);
    stream_total = MAX_SAMPLES * 2 + 2;

    // Random part. Each phase brings a new setting, cycling through the
    // extremes: streaming off, a zero ring, a ring above the limit, a zero
    // block size and a block of one byte. One phase runs with no idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      en = (phase % 4 != 3);
      case (phase % 3)
        0:       sig = 32'h0;
        1:       sig = 32'hFFFF_FFFF;
        default: sig = $urandom;
      endcase
      case (phase % 6)
        0:       ring = 21'd4;
        1:       ring = 21'(RING_LIMIT);
        2:       ring = 21'h1F_FFFF;
        3:       ring = 21'd0;
        4:       ring = RING_W'($urandom_range(4, 4096));
        default: ring = RING_W'($urandom_range(4, RING_LIMIT));
      endcase
      case (phase % 5)
        0:       blk = 21'd0;
        1:       blk = 21'd1;
        2:       blk = 21'(RING_LIMIT);
        3:       blk = 21'h1F_FFFF;
        default: blk = RING_W'($urandom_range(4, 2048));
      endcase
      apply_setting(en, sig, ring, blk, phase[0]);
      no_idle <= (phase == 5);
      for (int n = 0; n < PHASE_PACKETS; n++) begin
        random_packet();
        // Now and then the sender holds off until the block has gone idle.
        if ($urandom_range(0, 149) == 0) begin
          drain();
        end
      end
    end

    drain();
    repeat (50) @(posedge clk_i);

    $display("Sent %0d packets (%0d well formed) under %0d register settings;",
             packets_sent, well_formed_sent, settings_applied);
    $display("%0d results checked across streaming on and off, ring sizes from zero %s",
             results_checked, "past the limit, and block sizes from zero up.");
    if (mismatches == 0) begin
      $display("** iso_audio_packet_receiver: PASSED **");
    end else begin
      $display("** iso_audio_packet_receiver: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/iar_pkg.sv
hw/rtl/iso_audio_packet_receiver.sv
tb/iar_result_checker.sv
tb/tb.sv
